// ===== design/qed_pkg.sv =====
package qed_pkg;

  // Field widths
  localparam int unsigned IdxW    = 4;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PosW    = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned HistW   = 6;
  localparam int unsigned CfgIdxW = 2;

  // Default number of encoders
  localparam int unsigned NumEncodersDef = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCountMode  = 2'd0,
    CfgPressTime  = 2'd1,
    CfgRevGuard   = 2'd2,
    CfgRevWindow  = 2'd3
  } qed_cfg_idx_e;

  // Count modes; any other code selects the four-count table
  localparam logic [ModeW-1:0] ModeX1 = 2'd0;
  localparam logic [ModeW-1:0] ModeX2 = 2'd1;
  localparam logic [ModeW-1:0] ModeX4 = 2'd2;

  // Configuration reset values
  localparam logic [CfgW-1:0] PressTimeRst = 16'd100;
  localparam logic [CfgW-1:0] RevGuardRst  = 16'd50;
  localparam logic [CfgW-1:0] RevWindowRst = 16'd200;

  // Pulse flag bit positions
  localparam int unsigned FlagCw  = 0;
  localparam int unsigned FlagCcw = 1;

  typedef struct packed {
    logic [ModeW-1:0] count_mode;
    logic [CfgW-1:0]  press_time;
    logic [CfgW-1:0]  rev_guard;
    logic [CfgW-1:0]  rev_window;
  } qed_cfg_t;

  // Per-encoder state as kept in memory
  typedef struct packed {
    logic [HistW-1:0] hist;
    logic             prev_fwd;
    logic [TimeW-1:0] last_time;
    logic [PosW-1:0]  count;
    logic [1:0]       flags;
  } qed_entry_t;

  localparam qed_entry_t EntryRst = '{
    hist:      '0,
    prev_fwd:  1'b1,
    last_time: '0,
    count:     '0,
    flags:     '0
  };

  // Outcome of a transition table lookup
  typedef struct packed {
    logic step;
    logic fwd;
  } qed_trans_t;

  // Look up old pair (bits 3:2) and new pair (bits 1:0) in the selected table
  function automatic qed_trans_t qed_lookup(logic [ModeW-1:0] mode, logic [3:0] code);
    qed_trans_t t;
    t = '{step: 1'b0, fwd: 1'b0};
    case (mode)
      ModeX1: begin
        case (code)
          4'd4:    t = '{step: 1'b1, fwd: 1'b0};
          4'd8:    t = '{step: 1'b1, fwd: 1'b1};
          default: t = '{step: 1'b0, fwd: 1'b0};
        endcase
      end
      ModeX2: begin
        case (code)
          4'd4, 4'd11: t = '{step: 1'b1, fwd: 1'b0};
          4'd7, 4'd8:  t = '{step: 1'b1, fwd: 1'b1};
          default:     t = '{step: 1'b0, fwd: 1'b0};
        endcase
      end
      default: begin
        case (code)
          4'd2, 4'd4, 4'd11, 4'd13: t = '{step: 1'b1, fwd: 1'b0};
          4'd1, 4'd7, 4'd8, 4'd14:  t = '{step: 1'b1, fwd: 1'b1};
          default:                  t = '{step: 1'b0, fwd: 1'b0};
        endcase
      end
    endcase
    return t;
  endfunction

endpackage

// ===== design/qed_ram.sv =====
module qed_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/qed_update.sv =====
module qed_update
  import qed_pkg::*;
(
  input  qed_cfg_t         cfg_i,
  input  qed_entry_t       entry_i,
  input  logic             pin_a_i,
  input  logic             pin_b_i,
  input  logic [TimeW-1:0] now_i,
  output qed_entry_t       entry_o
);

  logic [1:0]       cur;
  logic             changed;
  logic             bounce;
  logic [HistW-1:0] hist_sh;
  qed_trans_t       trans;
  logic [TimeW-1:0] elapsed;
  logic             past_guard;
  logic             in_window;
  logic             past_press;
  logic             take;
  logic             dir_fwd;

  // Decode the new pin pair against the history
  assign cur        = {pin_b_i, pin_a_i};
  assign changed    = (cur != entry_i.hist[1:0]);
  assign hist_sh    = {entry_i.hist[3:0], cur};
  assign trans      = qed_lookup(cfg_i.count_mode, hist_sh[3:0]);
  assign bounce     = (cur == entry_i.hist[3:2]);

  // Time since the last step, modulo the counter width
  assign elapsed    = now_i - entry_i.last_time;
  assign past_guard = (elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.rev_guard});
  assign in_window  = (elapsed <= {{(TimeW-CfgW){1'b0}}, cfg_i.rev_window});
  assign past_press = (elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.press_time});

  // Accept the step, or turn a too-fast reversal into the old direction
  always_comb begin
    take    = 1'b0;
    dir_fwd = trans.fwd;
    if (changed && trans.step && !bounce) begin
      if (past_guard || (trans.fwd == entry_i.prev_fwd)) begin
        take    = 1'b1;
        dir_fwd = trans.fwd;
      end else if (in_window) begin
        take    = 1'b1;
        dir_fwd = entry_i.prev_fwd;
      end
    end
  end

  // Build the next entry; a taken step resets the elapsed time, so flags stay
  always_comb begin
    entry_o = entry_i;
    if (changed) begin
      entry_o.hist = hist_sh;
    end
    if (take) begin
      entry_o.count     = dir_fwd ? (entry_i.count + {{(PosW-1){1'b0}}, 1'b1})
                                  : (entry_i.count + {PosW{1'b1}});
      entry_o.prev_fwd  = dir_fwd;
      entry_o.last_time = now_i;
      if (dir_fwd) begin
        entry_o.flags[FlagCw] = 1'b1;
      end else begin
        entry_o.flags[FlagCcw] = 1'b1;
      end
    end else if (past_press) begin
      entry_o.flags = '0;
    end
  end

endmodule

// ===== design/quadrature_encoder_decoder_unit.sv =====
// Quadrature decoder for a bank of encoders sharing one sample stream.
// Input channel: one beat per pin sample (encoder_index_i, pin_a_level_i,
// pin_b_level_i, now_ms_i), taken when in_valid_i is high and in_stall_o low.
// Output channel: one beat per input beat, in order (encoder_id_o,
// cw_active_o, ccw_active_o, position_o), taken when out_valid_o is high and
// out_stall_i low. An index at or beyond the encoder count gives zeros and
// leaves all state untouched.
// Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i is
// high; write only while no beat is in flight.
// Path: an accepted beat passes the read stage, then the output register.
// Throughput: one beat per cycle unless the output stalls; the per-encoder
// state memory is read on accept and written back as the beat leaves the
// read stage; a one-entry bypass covers back-to-back beats to one encoder.
// Reset: configuration returns to its defaults, all encoder entries read as
// their reset state through per-entry valid bits, and the pipeline empties.
// Stall: a stalled result holds; one more beat may enter behind it, after
// which in_stall_o rises until the output drains.
module quadrature_encoder_decoder_unit
  import qed_pkg::*;
#(
  parameter int unsigned NumEncoders = NumEncodersDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [IdxW-1:0]        encoder_index_i,
  input  logic                   pin_a_level_i,
  input  logic                   pin_b_level_i,
  input  logic [TimeW-1:0]       now_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [IdxW-1:0]        encoder_id_o,
  output logic                   cw_active_o,
  output logic                   ccw_active_o,
  output logic signed [PosW-1:0] position_o
);

  localparam int unsigned AddrW   = (NumEncoders > 1) ? $clog2(NumEncoders) : 1;
  localparam int unsigned IdxExtW = 7;
  localparam logic [IdxExtW-1:0] NumEncExt = IdxExtW'(NumEncoders);

  qed_cfg_t cfg_q;

  logic [IdxExtW-1:0] idx_ext;
  logic               in_range;
  logic               accept_in;
  logic               out_ready;
  logic               s1_adv;

  logic               s1_valid_q;
  logic [IdxW-1:0]    s1_idx_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic               s1_in_range_q;
  logic               s1_a_q;
  logic               s1_b_q;
  logic [TimeW-1:0]   s1_now_q;

  logic [NumEncoders-1:0] ent_valid_q;
  logic                   wr_valid_q;
  logic [AddrW-1:0]       wr_addr_q;
  qed_entry_t             wr_entry_q;

  logic [$bits(qed_entry_t)-1:0] ram_rdata;
  qed_entry_t                    cur_entry;
  qed_entry_t                    new_entry;
  logic                          wr_en;

  logic             out_valid_q;
  logic [IdxW-1:0]  out_id_q;
  logic             out_cw_q;
  logic             out_ccw_q;
  logic [PosW-1:0]  out_pos_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{count_mode: ModeX4, press_time: PressTimeRst,
                 rev_guard: RevGuardRst, rev_window: RevWindowRst};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgCountMode: cfg_q.count_mode <= cfg_data_i[ModeW-1:0];
        CfgPressTime: cfg_q.press_time <= cfg_data_i;
        CfgRevGuard:  cfg_q.rev_guard  <= cfg_data_i;
        CfgRevWindow: cfg_q.rev_window <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the read stage advances whenever the output can take a beat
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign idx_ext  = {{(IdxExtW-IdxW){1'b0}}, encoder_index_i};
  assign in_range = (idx_ext < NumEncExt);

  // Read stage: capture the beat while the memory read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_in) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_idx_q      <= encoder_index_i;
      s1_addr_q     <= idx_ext[AddrW-1:0];
      s1_in_range_q <= in_range;
      s1_a_q        <= pin_a_level_i;
      s1_b_q        <= pin_b_level_i;
      s1_now_q      <= now_ms_i;
    end
  end

  // Per-encoder state memory
  assign wr_en = s1_adv && s1_in_range_q;

  qed_ram #(
    .Width ($bits(qed_entry_t)),
    .Depth (NumEncoders),
    .AddrW (AddrW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_entry),
    .re_i    (accept_in),
    .raddr_i (idx_ext[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Hold the last write back for the bypass, mark entries as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q  <= 1'b0;
      ent_valid_q <= '0;
    end else if (wr_en) begin
      wr_valid_q             <= 1'b1;
      ent_valid_q[s1_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wr_addr_q  <= s1_addr_q;
      wr_entry_q <= new_entry;
    end
  end

  // Pick bypass, reset state or memory data
  always_comb begin
    if (wr_valid_q && (wr_addr_q == s1_addr_q)) begin
      cur_entry = wr_entry_q;
    end else if (!ent_valid_q[s1_addr_q]) begin
      cur_entry = EntryRst;
    end else begin
      cur_entry = qed_entry_t'(ram_rdata);
    end
  end

  qed_update u_update (
    .cfg_i   (cfg_q),
    .entry_i (cur_entry),
    .pin_a_i (s1_a_q),
    .pin_b_i (s1_b_q),
    .now_i   (s1_now_q),
    .entry_o (new_entry)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_id_q  <= s1_idx_q;
      out_cw_q  <= s1_in_range_q && new_entry.flags[FlagCw];
      out_ccw_q <= s1_in_range_q && new_entry.flags[FlagCcw];
      out_pos_q <= s1_in_range_q ? new_entry.count : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign encoder_id_o = out_id_q;
  assign cw_active_o  = out_cw_q;
  assign ccw_active_o = out_ccw_q;
  assign position_o   = $signed(out_pos_q);

endmodule

// ===== design/qed_checker.sv =====
module qed_checker
  import qed_pkg::*;
#(
  parameter int unsigned NumEncoders = NumEncodersDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [IdxW-1:0]        encoder_id_o,
  input logic                   cw_active_o,
  input logic                   ccw_active_o,
  input logic signed [PosW-1:0] position_o
);

  localparam int unsigned IdxExtW = 7;
  localparam logic [IdxExtW-1:0] NumEncExt = IdxExtW'(NumEncoders);

  logic [IdxExtW-1:0] id_ext;
  assign id_ext = {{(IdxExtW-IdxW){1'b0}}, encoder_id_o};

  // Keep a stalled output beat
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // Keep a stalled output payload
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(position_o) && $stable(encoder_id_o)
      && $stable(cw_active_o) && $stable(ccw_active_o))
    else $error("output payload changed while stalled");

  // Stall the input only when a result is waiting behind a stalled output
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // Report zeros for an encoder index outside the bank
  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (id_ext >= NumEncExt) |->
      !cw_active_o && !ccw_active_o && (position_o == '0))
    else $error("out-of-range encoder reported nonzero state");

endmodule

bind quadrature_encoder_decoder_unit qed_checker #(
  .NumEncoders (NumEncoders)
) u_qed_checker (.*);
